// ===== rtl/core/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

  localparam int unsigned NUM_WORDS = 5;

  localparam logic [31:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_00_19 = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN  = 6'd56;

  localparam logic [6:0] RND_20   = 7'd20;
  localparam logic [6:0] RND_40   = 7'd40;
  localparam logic [6:0] RND_60   = 7'd60;
  localparam logic [6:0] RND_LAST = 7'd79;

  localparam logic [2:0] WORD_LAST = 3'd4;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift;
    byte_sel_t byte_sel;
    logic      count_bits;
    logic      load_work;
    logic      round;
    logic [6:0] rnd;
    logic      fold;
    logic      reinit;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned s);
    rol = (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] sha_f(input logic [6:0] rnd, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    if (rnd < RND_20) begin
      sha_f = (b & c) | (~b & d);
    end else if (rnd < RND_40) begin
      sha_f = b ^ c ^ d;
    end else if (rnd < RND_60) begin
      sha_f = (b & c) | (b & d) | (c & d);
    end else begin
      sha_f = b ^ c ^ d;
    end
  endfunction

  function automatic logic [31:0] sha_k(input logic [6:0] rnd);
    if (rnd < RND_20) begin
      sha_k = K_00_19;
    end else if (rnd < RND_40) begin
      sha_k = K_20_39;
    end else if (rnd < RND_60) begin
      sha_k = K_40_59;
    end else begin
      sha_k = K_60_79;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha1_datapath.sv =====
`default_nettype none

module sha1_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_tdata,
  input  wire sha1_pkg::cmd_t    cmd,
  output sha1_pkg::status_t      sts,
  output logic [31:0]            out_tdata,
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);
  import sha1_pkg::*;

  logic [511:0] sr_r;
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [31:0]  h_r [NUM_WORDS];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;

  logic [7:0]  byte_in;
  logic [5:0]  len_shift;
  logic [31:0] w0, w2, w8, w13, w_new, tmp;

  always_comb begin
    len_shift = {3'd7 - fill_r[2:0], 3'b000};
    case (cmd.byte_sel)
      SEL_MSG:  byte_in = in_tdata;
      SEL_PAD:  byte_in = PAD_BYTE;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = bits_r[len_shift +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  assign w0    = sr_r[511:480];
  assign w2    = sr_r[447:416];
  assign w8    = sr_r[255:224];
  assign w13   = sr_r[95:64];
  assign w_new = rol(w13 ^ w8 ^ w2 ^ w0, 1);
  assign tmp   = rol(a_r, 5) + sha_f(cmd.rnd, b_r, c_r, d_r) + e_r + sha_k(cmd.rnd) + w0;

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      sr_r <= {sr_r[503:0], byte_in};
    end else if (cmd.round) begin
      sr_r <= {sr_r[479:0], w_new};
    end
    if (cmd.load_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= rol(b_r, 30);
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      fill_r <= '0;
      bits_r <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        h_r[i] <= H_INIT[i];
      end
    end else begin
      if (cmd.shift) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.count_bits) begin
        bits_r <= bits_r + 64'd8;
      end
      if (cmd.fold) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end
    end
  end

  assign sts.fill  = fill_r;
  assign out_tdata = h_r[cmd.idx];
  assign out_tuser = cmd.idx;
  assign out_tlast = (cmd.idx == WORD_LAST);

endmodule

`default_nettype wire

// ===== rtl/core/sha1_ctrl.sv =====
`default_nettype none

module sha1_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tuser,
  input  wire logic              in_tlast,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire sha1_pkg::status_t sts,
  output sha1_pkg::cmd_t         cmd
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    P_IDLE,
    P_PAD,
    P_OUT
  } post_t;

  state_t     state_r, state_nxt;
  post_t      post_r, post_nxt;
  logic       pad_first_r, pad_first_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       in_tready_r, out_tvalid_r;
  logic       in_acc, out_acc, wrap;

  assign in_acc  = in_tvalid && in_tready_r;
  assign out_acc = out_tvalid_r && out_tready;
  assign wrap    = (sts.fill == FILL_LAST);

  always_comb begin
    state_nxt     = state_r;
    post_nxt      = post_r;
    pad_first_nxt = pad_first_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.byte_sel  = SEL_MSG;
    cmd.rnd       = rnd_r;
    cmd.idx       = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            cmd.shift      = 1'b1;
            cmd.count_bits = 1'b1;
          end
          if (in_tuser && wrap) begin
            state_nxt     = S_ROUND;
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            post_nxt      = in_tlast ? P_PAD : P_IDLE;
            pad_first_nxt = 1'b1;
          end else if (in_tlast) begin
            state_nxt     = S_PAD;
            pad_first_nxt = 1'b1;
          end
        end
      end
      S_PAD: begin
        cmd.shift = 1'b1;
        if (pad_first_r || sts.fill != FILL_LEN) begin
          cmd.byte_sel  = pad_first_r ? SEL_PAD : SEL_ZERO;
          pad_first_nxt = 1'b0;
          if (wrap) begin
            state_nxt     = S_ROUND;
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            post_nxt      = P_PAD;
          end
        end else begin
          cmd.byte_sel = SEL_LEN;
          state_nxt    = S_LEN;
        end
      end
      S_LEN: begin
        cmd.shift    = 1'b1;
        cmd.byte_sel = SEL_LEN;
        if (wrap) begin
          state_nxt     = S_ROUND;
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          post_nxt      = P_OUT;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        case (post_r)
          P_IDLE:  state_nxt = S_IDLE;
          P_PAD:   state_nxt = S_PAD;
          P_OUT: begin
            state_nxt = S_OUT;
            idx_nxt   = '0;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (out_acc) begin
          if (idx_r == WORD_LAST) begin
            cmd.reinit = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      post_r       <= P_IDLE;
      pad_first_r  <= 1'b0;
      rnd_r        <= '0;
      idx_r        <= '0;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      post_r       <= post_nxt;
      pad_first_r  <= pad_first_nxt;
      rnd_r        <= rnd_nxt;
      idx_r        <= idx_nxt;
      in_tready_r  <= (state_nxt == S_IDLE);
      out_tvalid_r <= (state_nxt == S_OUT);
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready_r && out_tvalid_r))
    else $error("input and output sides open together");

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (rnd_r <= RND_LAST))
    else $error("round counter out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (idx_r <= WORD_LAST))
    else $error("digest word index out of range");

  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && idx_r == WORD_LAST) |=> (in_tready_r && !out_tvalid_r))
    else $error("input not reopened after final digest word");

  a_len_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEN) |-> (sts.fill >= FILL_LEN))
    else $error("length bytes outside their slot");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sha1_hash_engine_top.sv =====
`default_nettype none

// SHA-1 digest over a byte stream. Each input request carries one byte in
// in_tdata when in_tuser is high; in_tlast closes the message (an empty
// closing request is allowed, giving the digest of the empty message).
// Data bytes are taken while the engine is idle. Every 64th byte stalls
// the input while the shared round unit runs 80 rounds and folds the
// result into the chaining words. Closing a message pads one byte per
// cycle through the block shift register, pausing while a filled block
// is compressed; when the length does not fit, that block is compressed
// and a further block of zero bytes and the length follows. After the
// final block is compressed, the digest appears as five big-endian
// words, word 0 first, on out_tdata with the word index on out_tuser
// and out_tlast on word 4.
// The input stays stalled until the last digest word is taken, after which
// the engine is ready for the next message.
module sha1_hash_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] message_byte
  input  wire logic        in_tuser,    // has_byte
  input  wire logic        in_tlast,    // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [31:0] digest_word
  output logic [2:0]       out_tuser,   // [2:0] word_index
  output logic             out_tlast    // last_word
);
  import sha1_pkg::*;

  cmd_t    cmd;
  status_t sts;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sha1_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

// ===== verif/tb_sha1_hash_engine_top.sv =====
`timescale 1ns / 100ps

module tb_sha1_hash_engine_top;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RAND_ITEMS  = 270;
  localparam int unsigned IDLE_PCT    = 16;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned LEN_SLOT    = 56;
  localparam int unsigned BLOCK_BYTES = 64;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  byte_req_t    req_q[$];
  digest_word_t digest_q[$];
  byte_req_t    next_req;
  bit           in_fire = 1'b0;

  logic [31:0] hash_chain [sha1_pkg::NUM_WORDS];
  logic [63:0] msg_bits;
  logic [7:0]  blk_buf [BLOCK_BYTES];
  logic [5:0]  blk_fill;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_queued = 0;
  int unsigned n_sent = 0;
  int unsigned n_msgs = 0;
  int unsigned n_words = 0;

  sha1_hash_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void restart_message();
    for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
      hash_chain[i] = sha1_pkg::H_INIT[i];
    end
    msg_bits = 64'd0;
    blk_fill = 6'd0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] x, a, b, c, d, e, f, k, tmp;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    end
    for (int t = 16; t < 80; t++) begin
      x = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
      w[t] = {x[30:0], x[31]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K_00_19;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K_20_39;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K_40_59;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K_60_79;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + w[t];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void absorb_request(input byte_req_t r);
    int pos;
    digest_word_t dw;
    if (r.has_byte) begin
      blk_buf[blk_fill] = r.data;
      msg_bits += 64'd8;
      blk_fill += 6'd1;
      if (blk_fill == 6'd0) begin
        sha1_compress();
      end
    end
    if (!r.eom) begin
      return;
    end
    pos = int'(blk_fill);
    blk_buf[pos] = sha1_pkg::PAD_BYTE;
    pos = pos + 1;
    if (pos > LEN_SLOT) begin
      while (pos < BLOCK_BYTES) begin
        blk_buf[pos] = 8'h00;
        pos = pos + 1;
      end
      sha1_compress();
      pos = 0;
    end
    while (pos < LEN_SLOT) begin
      blk_buf[pos] = 8'h00;
      pos = pos + 1;
    end
    for (int i = 0; i < 8; i++) begin
      blk_buf[LEN_SLOT + i] = msg_bits[63 - 8*i -: 8];
    end
    sha1_compress();
    for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
      dw.word = hash_chain[i];
      dw.idx  = i[2:0];
      dw.last = (i == sha1_pkg::NUM_WORDS - 1);
      digest_q = {digest_q, dw};
    end
    restart_message();
  endfunction

  // queue one message; close on the last byte or with a separate empty request
  task automatic queue_message(input int unsigned len, input bit close_alone);
    byte_req_t r;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 5) begin
        r.data = 8'($urandom_range(0, 255));
        r.has_byte = 1'b0;
        r.eom = 1'b0;
        req_q = {req_q, r};
      end
      r.data = 8'($urandom_range(0, 255));
      r.has_byte = 1'b1;
      r.eom = !close_alone && (i == len - 1);
      req_q = {req_q, r};
      n_queued++;
    end
    if (close_alone || len == 0) begin
      r.data = 8'($urandom_range(0, 255));
      r.has_byte = 1'b0;
      r.eom = 1'b1;
      req_q = {req_q, r};
      n_queued++;
    end
  endtask

  function automatic void push_req(input logic [7:0] data, input logic has_byte,
                                   input logic eom);
    byte_req_t r;
    r.data = data;
    r.has_byte = has_byte;
    r.eom = eom;
    req_q = {req_q, r};
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_sha1_hash_engine_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      next_req.data = in_tdata;
      next_req.has_byte = in_tuser;
      next_req.eom = in_tlast;
      if (in_tlast) begin
        n_msgs++;
      end
      absorb_request(next_req);
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_words++;
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest word: expected none, got %h idx %0d last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        exp_w = digest_q.pop_front();
        if (out_tdata !== exp_w.word) begin
          errors++;
          $display("%0t: digest_word idx %0d: expected %h, got %h",
                   $time, exp_w.idx, exp_w.word, out_tdata);
        end
        if (out_tuser !== exp_w.idx) begin
          errors++;
          $display("%0t: word_index: expected %0d, got %0d", $time, exp_w.idx, out_tuser);
        end
        if (out_tlast !== exp_w.last) begin
          errors++;
          $display("%0t: last_word idx %0d: expected %0b, got %0b",
                   $time, exp_w.idx, exp_w.last, out_tlast);
        end
      end
    end
  end

  // hold each request until taken; no gaps in the middle of the run on either side
  always @(negedge clk) begin
    byte_req_t r;
    bit calm_in;
    bit calm_out;
    calm_in = (n_sent >= 120) && (n_sent < 180);
    calm_out = (n_words >= 30) && (n_words < 60);
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (req_q.size() > 0 && (calm_in || $urandom_range(0, 99) >= IDLE_PCT)) begin
          r = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= r.data;
          in_tuser <= r.has_byte;
          in_tlast <= r.eom;
          n_sent++;
        end else begin
          in_tvalid <= 1'b0;
          in_tdata <= 8'($urandom_range(0, 255));
          in_tuser <= 1'($urandom_range(0, 1));
          in_tlast <= 1'($urandom_range(0, 1));
        end
      end
      out_tready <= calm_out || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    restart_message();
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      blk_buf[i] = 8'h00;
    end

    push_req(8'h3C, 1'b0, 1'b1);
    push_req(8'hA5, 1'b0, 1'b0);
    push_req(8'h61, 1'b1, 1'b0);
    push_req(8'h62, 1'b1, 1'b0);
    push_req(8'h63, 1'b1, 1'b1);
    push_req(8'h00, 1'b1, 1'b0);
    push_req(8'hFF, 1'b1, 1'b0);
    push_req(8'hC3, 1'b0, 1'b1);
    push_req(8'hFF, 1'b0, 1'b1);
    push_req(8'h96, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b1);
    push_req(8'h80, 1'b1, 1'b1);
    push_req(8'h7F, 1'b1, 1'b0);
    push_req(8'h5A, 1'b0, 1'b0);
    push_req(8'hFF, 1'b1, 1'b1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain everything before the random part
    while (req_q.size() != 0 || in_tvalid || digest_q.size() != 0) begin
      @(posedge clk);
    end

    queue_message(55, 1'($urandom_range(0, 1)));
    queue_message(56, 1'($urandom_range(0, 1)));
    queue_message(64, 1'($urandom_range(0, 1)));
    while (n_queued < RAND_ITEMS) begin
      queue_message($urandom_range(0, 20), 1'($urandom_range(0, 1)));
    end

    while (req_q.size() != 0 || in_tvalid || digest_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("requests sent: %0d, messages closed: %0d, digest words checked: %0d",
             n_sent, n_msgs, n_words);
    $display("covered empty and one-block messages, pad boundaries at 55/56/64 bytes");
    if (errors == 0) begin
      $display("tb_sha1_hash_engine_top: clean");
    end else begin
      $display("tb_sha1_hash_engine_top: errors");
    end
    $finish;
  end

endmodule
